// ===== rtl/lane_marking_row_filter_core_assert.svh =====
// Assertion macros shared by the lane marking row filter checker.
`ifndef LANE_MARKING_ROW_FILTER_CORE_ASSERT_SVH
`define LANE_MARKING_ROW_FILTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LMRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lmrf_pkg.sv =====
// Shared constants, codes and types of the lane marking row filter.
`timescale 1ns / 1ps
package lmrf_pkg;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int TS_W       = 9;
    localparam int TAU_W      = 10;
    localparam int POS_W      = 10;
    localparam int THR_W      = 8;
    localparam int NUM_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;

    // Input action codes carried on tuser
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic             start;
        logic [TS_W-1:0]  tau_start;
        logic [TS_W-1:0]  tau_end;
        logic [DIM_W-1:0] divisor;
        logic [DIM_W-1:0] near_span;
        logic [DIM_W-1:0] far_span;
    } t_tau_req;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [TS_W-1:0] quotient;
    } t_tau_rsp;

    typedef enum logic [3:0] {
        EM_IDLE   = 4'b0001,
        EM_READ_A = 4'b0010,
        EM_READ_B = 4'b0100,
        EM_CALC   = 4'b1000
    } t_emit_state;

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_MUL  = 3'b010,
        DV_DIV  = 3'b100
    } t_div_state;

endpackage

// ===== rtl/lane_marking_row_filter_core.sv =====
// Lane marking row filter: pixel stream in, one filtered pixel out per emission.
// Pixels arrive on s_axis with tuser = 0; tuser = 1 drains the next held pixel of the
// previous row. Rows are written into one half of a dual-bank line store while the
// other half is filtered. An item that emits a pixel reads the pixel on acceptance and
// its two neighbours in EM_READ_A and EM_READ_B from the single-read-port line store;
// it then forms the result in EM_CALC; other items are only accepted. When a row in the
// lower half of the frame completes, its neighbour offset is worked out by an iterative
// divider that holds s_axis_tready and the configuration port low while busy. A result
// waits in the output register while the next item is taken; emission stalls in its
// final stage only if that register is full. The line store is not cleared at reset.
`timescale 1ns / 1ps
module lane_marking_row_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lmrf_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel_value
    input  logic                             s_axis_tuser,   // [0] action
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] filtered_value, [8] mark, [18:9] out_column, [28:19] out_row, [31:29] zero
    output logic [lmrf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast,   // last_of_frame
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lmrf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lmrf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lmrf_pkg::*;

    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int CW        = $clog2(MAX_WIDTH + 1);
    localparam int RW        = $clog2(MAX_HEIGHT);
    localparam int XW        = ((CW > DIM_W) ? CW : DIM_W) + 2;
    localparam int XH        = ((RW + 1 > DIM_W) ? RW + 1 : DIM_W) + 1;
    localparam int MEM_DEPTH = 2 ** (AW + 1);

    // configuration
    logic [DIM_W-1:0] r_cfg_width, r_cfg_height;
    logic [TS_W-1:0]  r_cfg_tau_start, r_cfg_tau_end;
    logic [THR_W-1:0] r_cfg_threshold;
    logic [DIM_W-1:0] eff_w, eff_h;

    // row state
    logic             r_load_bank;
    logic [AW-1:0]    r_load_col;
    logic [RW-1:0]    r_load_row;
    logic             r_held_valid;
    logic [RW-1:0]    r_held_row;
    logic [TAU_W-1:0] r_held_tau;
    logic [CW-1:0]    r_emit_col;

    // emission context
    t_emit_state      r_state, n_state;
    logic             r_e_bank;
    logic [AW-1:0]    r_e_lo, r_e_hi;
    logic             r_e_in_range;
    logic             r_e_last;
    logic [POS_W-1:0] r_e_row_out, r_e_col_out;
    logic [PIX_W-1:0] r_p, r_a;

    // line store
    logic [PIX_W-1:0] r_line_mem [MEM_DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic             rd_en, wr_en;
    logic [AW:0]      rd_addr, wr_addr;

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_value;
    logic             r_out_mark;
    logic [POS_W-1:0] r_out_col, r_out_row;
    logic             r_out_last;

    // per-item decode
    logic             in_acc, is_pixel, idle_ready, out_free;
    logic [XW-1:0]    emit_c_x, w_x, tau_x;
    logic             emit_go, emit_ends, in_range, last_pix;
    logic             row_done, row_wrap, tau_flat;
    logic [XH-1:0]    r2_x, h_x;

    // filter arithmetic
    logic [PIX_W-1:0] nb_max, diff, calc_v;

    t_tau_req tau_req;
    t_tau_rsp tau_rsp;

    // 0 acts as 1, oversize saturates to the store size
    assign eff_w = (r_cfg_width == '0) ? DIM_W'(1) :
                   ((XW'(r_cfg_width) > XW'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_cfg_width);
    assign eff_h = (r_cfg_height == '0) ? DIM_W'(1) :
                   ((XH'(r_cfg_height) > XH'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_cfg_height);

    assign idle_ready    = (r_state == EM_IDLE) && !tau_rsp.busy;
    assign s_axis_tready = idle_ready;
    assign o_cfg_ready   = idle_ready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_pixel      = (s_axis_tuser == ACT_PIXEL);
    assign out_free      = !r_out_valid || m_axis_tready;

    assign emit_c_x  = XW'(r_emit_col);
    assign w_x       = XW'(eff_w);
    assign tau_x     = XW'(r_held_tau);
    assign emit_go   = r_held_valid && (emit_c_x < w_x);
    assign emit_ends = (emit_c_x + XW'(1)) >= w_x;
    assign in_range  = (emit_c_x >= tau_x) && ((emit_c_x + tau_x) < w_x);
    assign h_x       = XH'(eff_h);
    assign last_pix  = ((XH'(r_held_row) + XH'(1)) == h_x) && ((emit_c_x + XW'(1)) == w_x);

    assign row_done  = (XW'(r_load_col) + XW'(1)) >= w_x;
    assign row_wrap  = (XH'(r_load_row) + XH'(1)) >= h_x;
    assign r2_x      = XH'(r_load_row) << 1;
    assign tau_flat  = (r2_x <= h_x);

    assign tau_req.start     = in_acc && is_pixel && row_done && !tau_flat;
    assign tau_req.tau_start = r_cfg_tau_start;
    assign tau_req.tau_end   = r_cfg_tau_end;
    assign tau_req.divisor   = eff_h;
    assign tau_req.near_span = DIM_W'((h_x << 1) - r2_x);
    assign tau_req.far_span  = DIM_W'(r2_x - h_x);

    lmrf_tau_div u_tau_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tau_req),
        .o_rsp   (tau_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width     <= DIM_W'(640);
            r_cfg_height    <= DIM_W'(480);
            r_cfg_tau_start <= '0;
            r_cfg_tau_end   <= '0;
            r_cfg_threshold <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIDTH:     r_cfg_width     <= i_cfg_data;
                CFG_HEIGHT:    r_cfg_height    <= i_cfg_data;
                CFG_TAU_START: r_cfg_tau_start <= i_cfg_data[TS_W-1:0];
                CFG_TAU_END:   r_cfg_tau_end   <= i_cfg_data[TS_W-1:0];
                CFG_THRESHOLD: r_cfg_threshold <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // line store ports: loading bank written, held bank read
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {~r_load_bank, r_emit_col[AW-1:0]};
        case (r_state)
            EM_IDLE: begin
                rd_en = in_acc && emit_go;
            end
            EM_READ_A: begin
                rd_en   = 1'b1;
                rd_addr = {r_e_bank, r_e_lo};
            end
            EM_READ_B: begin
                rd_en   = 1'b1;
                rd_addr = {r_e_bank, r_e_hi};
            end
            default: begin
            end
        endcase
    end

    assign wr_en   = in_acc && is_pixel;
    assign wr_addr = {r_load_bank, r_load_col};

    always_ff @(posedge i_clk) begin
        if (wr_en) r_line_mem[wr_addr] <= s_axis_tdata[PIX_W-1:0];
        if (rd_en) r_rd_data <= r_line_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            EM_IDLE: begin
                if (in_acc && emit_go) n_state = EM_READ_A;
            end
            EM_READ_A: begin
                n_state = EM_READ_B;
            end
            EM_READ_B: begin
                n_state = EM_CALC;
            end
            EM_CALC: begin
                if (out_free) n_state = EM_IDLE;
            end
            default: begin
                n_state = EM_IDLE;
            end
        endcase
    end

    // row bookkeeping; emission context is latched first so the row swap can follow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= EM_IDLE;
            r_load_bank  <= 1'b0;
            r_load_col   <= '0;
            r_load_row   <= '0;
            r_held_valid <= 1'b0;
            r_held_row   <= '0;
            r_held_tau   <= '0;
            r_emit_col   <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (emit_go) begin
                    r_emit_col <= r_emit_col + CW'(1);
                    if (emit_ends) r_held_valid <= 1'b0;
                end else begin
                    r_held_valid <= 1'b0;
                end
                if (is_pixel) begin
                    if (row_done) begin
                        r_held_valid <= 1'b1;
                        r_emit_col   <= '0;
                        r_held_row   <= r_load_row;
                        if (tau_flat) r_held_tau <= TAU_W'(r_cfg_tau_start);
                        r_load_bank  <= ~r_load_bank;
                        r_load_col   <= '0;
                        r_load_row   <= row_wrap ? '0 : r_load_row + RW'(1);
                    end else begin
                        r_load_col <= r_load_col + AW'(1);
                    end
                end
            end
            if (tau_rsp.done) r_held_tau <= TAU_W'(tau_rsp.quotient);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emit_go) begin
            r_e_bank     <= ~r_load_bank;
            r_e_lo       <= AW'(emit_c_x - tau_x);
            r_e_hi       <= AW'(emit_c_x + tau_x);
            r_e_in_range <= in_range;
            r_e_last     <= last_pix;
            r_e_row_out  <= POS_W'(r_held_row);
            r_e_col_out  <= POS_W'(r_emit_col);
        end
        if (r_state == EM_READ_A) r_p <= r_rd_data;
        if (r_state == EM_READ_B) r_a <= r_rd_data;
    end

    // 2p - a - b - |a-b| = 2*(p - max(a,b))
    assign nb_max = (r_a > r_rd_data) ? r_a : r_rd_data;
    assign diff   = r_p - nb_max;
    always_comb begin
        if (!r_e_in_range || (r_p <= nb_max)) begin
            calc_v = '0;
        end else if (diff[PIX_W-1]) begin
            calc_v = {PIX_W{1'b1}};
        end else begin
            calc_v = {diff[PIX_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == EM_CALC) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == EM_CALC) && out_free) begin
            r_out_value <= calc_v;
            r_out_mark  <= (calc_v > r_cfg_threshold);
            r_out_col   <= r_e_col_out;
            r_out_row   <= r_e_row_out;
            r_out_last  <= r_e_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_row, r_out_col, r_out_mark, r_out_value};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/lmrf_tau_div.sv =====
// Iterative row offset unit: weighted sum then restoring division by the height.
`timescale 1ns / 1ps
module lmrf_tau_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lmrf_pkg::t_tau_req i_req,
    output lmrf_pkg::t_tau_rsp o_rsp
);
    import lmrf_pkg::*;

    localparam int STEP_W = $clog2(TS_W);

    t_div_state        r_state, n_state;
    logic [NUM_W-1:0]  r_prod;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dvs;
    logic [TS_W-1:0]   r_te;
    logic [TS_W-1:0]   r_quo;
    logic [DIM_W-1:0]  r_far;
    logic [STEP_W-1:0] r_step;
    logic              r_done;
    logic              rem_ge;

    assign rem_ge = (r_rem >= r_dvs);

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE: begin
                if (i_req.start) n_state = DV_MUL;
            end
            DV_MUL: begin
                n_state = DV_DIV;
            end
            DV_DIV: begin
                if (r_step == '0) n_state = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == DV_DIV) && (r_step == '0);
        end
    end

    // n = ts*(2h-2r) + te*(2r-h); quotient never exceeds 9 bits
    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    r_prod <= NUM_W'(i_req.tau_start) * NUM_W'(i_req.near_span);
                    r_te   <= i_req.tau_end;
                    r_far  <= i_req.far_span;
                    r_dvs  <= NUM_W'({i_req.divisor, {(TS_W-1){1'b0}}});
                    r_step <= STEP_W'(TS_W - 1);
                end
            end
            DV_MUL: begin
                r_rem <= r_prod + NUM_W'(r_te) * NUM_W'(r_far);
            end
            DV_DIV: begin
                if (rem_ge) r_rem <= r_rem - r_dvs;
                r_quo  <= {r_quo[TS_W-2:0], rem_ge};
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.busy     = (r_state != DV_IDLE) || r_done;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/lmrf_checker.sv =====
// Port-level checks on the lane marking row filter, bound to the top level.
`timescale 1ns / 1ps
`include "lane_marking_row_filter_core_assert.svh"
module lmrf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           o_cfg_ready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lmrf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    // a stalled result must not change
    `LMRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // the response is twice a difference, so odd only when saturated
    `LMRF_ASSERT_NOW(a_even_or_sat, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[7:0] == 8'hFF, "odd response below saturation")

    // a zero response can never exceed the threshold
    `LMRF_ASSERT_NOW(a_zero_no_mark, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[7:0] == 8'h00), !m_axis_tdata[8], "mark set on zero response")

    // configuration is only taken when the pixel side could be
    `LMRF_ASSERT_NOW(a_cfg_idle, i_clk, i_rst_n, 1'b1, o_cfg_ready == s_axis_tready, "configuration ready while busy")

endmodule

bind lane_marking_row_filter_core lmrf_checker u_lmrf_checker (.*);
